### hdl/vru_pkg.sv
package vru_pkg;

    localparam int F      = 16;
    localparam int IN_W   = 18;
    localparam int OUT_W  = 20;
    localparam int DOT_W  = 2 * IN_W + 2;
    localparam int COS_W  = DOT_W + 1 - F;
    localparam int NC_W   = IN_W + COS_W;
    localparam int P_W    = NC_W - F + 1;
    localparam int EP_W   = P_W + IN_W + 1;
    localparam int Q_W    = EP_W - F;
    localparam int LEN_W  = 2 * Q_W + 2;
    localparam int ROOT_W = LEN_W / 2;
    localparam int SQ_W   = LEN_W + 1;
    localparam int PAR_W  = IN_W + ROOT_W + 2;
    localparam int SUM_W  = PAR_W - F + 1;

    typedef logic signed [IN_W-1:0] t_in;
    typedef logic signed [Q_W-1:0]  t_q;

    // normal and perpendicular part, carried alongside the square root
    typedef struct packed {
        t_in n0;
        t_in n1;
        t_in n2;
        t_q  q0;
        t_q  q1;
        t_q  q2;
    } t_side;

    typedef struct packed {
        logic en;
        logic valid;
    } t_ctl;

endpackage

### hdl/vru_front.sv
module vru_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  vru_pkg::t_ctl                i_ctl,
    input  vru_pkg::t_in                 i_dir [3],
    input  vru_pkg::t_in                 i_norm [3],
    input  logic [vru_pkg::IN_W-1:0]     i_eta,
    output logic                         o_valid,
    output logic [vru_pkg::LEN_W-1:0]    o_diff,
    output vru_pkg::t_side               o_side
);

    localparam int F     = vru_pkg::F;
    localparam int IN_W  = vru_pkg::IN_W;
    localparam int DOT_W = vru_pkg::DOT_W;
    localparam int COS_W = vru_pkg::COS_W;
    localparam int NC_W  = vru_pkg::NC_W;
    localparam int P_W   = vru_pkg::P_W;
    localparam int EP_W  = vru_pkg::EP_W;
    localparam int Q_W   = vru_pkg::Q_W;
    localparam int LEN_W = vru_pkg::LEN_W;

    logic [7:0] r_vld;

    // stage 1
    logic signed [2*IN_W-1:0] r1_prod [3];
    vru_pkg::t_in             r1_d [3];
    vru_pkg::t_in             r1_n [3];
    logic [IN_W-1:0]          r1_eta;
    // stage 2
    logic signed [COS_W-1:0]  r2_cos;
    vru_pkg::t_in             r2_d [3];
    vru_pkg::t_in             r2_n [3];
    logic [IN_W-1:0]          r2_eta;
    // stage 3
    logic signed [NC_W-1:0]   r3_nc [3];
    vru_pkg::t_in             r3_d [3];
    vru_pkg::t_in             r3_n [3];
    logic [IN_W-1:0]          r3_eta;
    // stage 4
    logic signed [P_W-1:0]    r4_p [3];
    vru_pkg::t_in             r4_n [3];
    logic [IN_W-1:0]          r4_eta;
    // stage 5
    logic signed [EP_W-1:0]   r5_ep [3];
    vru_pkg::t_in             r5_n [3];
    // stage 6
    vru_pkg::t_q              r6_q [3];
    vru_pkg::t_in             r6_n [3];
    // stage 7
    logic [2*Q_W-1:0]         r7_sq [3];
    vru_pkg::t_q              r7_q [3];
    vru_pkg::t_in             r7_n [3];
    // stage 8
    logic [LEN_W-1:0]         r8_diff;
    vru_pkg::t_q              r8_q [3];
    vru_pkg::t_in             r8_n [3];

    logic signed [DOT_W-1:0]  n_dot;
    logic signed [DOT_W-1:0]  n_negs;
    logic signed [COS_W-1:0]  n_cos;
    logic signed [P_W-1:0]    n_p [3];
    vru_pkg::t_q              n_q [3];
    logic [Q_W-1:0]           n_abs [3];
    logic [LEN_W-1:0]         n_len;
    logic [LEN_W-1:0]         n_diff;

    localparam logic signed [DOT_W-1:0] ONE  = DOT_W'(1) <<< F;
    localparam logic [LEN_W-1:0]        ONE2 = LEN_W'(1) << (2 * F);

    always_comb begin
        n_dot  = DOT_W'(r1_prod[0]) + DOT_W'(r1_prod[1]) + DOT_W'(r1_prod[2]);
        n_negs = (-n_dot) >>> F;
        n_cos  = (n_negs > ONE) ? COS_W'(ONE) : n_negs[COS_W-1:0];
        for (int i = 0; i < 3; i++) begin
            n_p[i]   = P_W'(r3_d[i]) + P_W'(r3_nc[i] >>> F);
            n_q[i]   = Q_W'(r5_ep[i] >>> F);
            n_abs[i] = r6_q[i][Q_W-1] ? Q_W'(-r6_q[i]) : Q_W'(r6_q[i]);
        end
        n_len  = LEN_W'(r7_sq[0]) + LEN_W'(r7_sq[1]) + LEN_W'(r7_sq[2]);
        n_diff = (n_len >= ONE2) ? (n_len - ONE2) : (ONE2 - n_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= {r_vld[6:0], i_ctl.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int i = 0; i < 3; i++) begin
                r1_prod[i] <= i_dir[i] * i_norm[i];
                r1_d[i]    <= i_dir[i];
                r1_n[i]    <= i_norm[i];
                r2_d[i]    <= r1_d[i];
                r2_n[i]    <= r1_n[i];
                r3_nc[i]   <= NC_W'(r2_n[i]) * NC_W'(r2_cos);
                r3_d[i]    <= r2_d[i];
                r3_n[i]    <= r2_n[i];
                r4_p[i]    <= n_p[i];
                r4_n[i]    <= r3_n[i];
                r5_ep[i]   <= EP_W'($signed({1'b0, r4_eta})) * EP_W'(r4_p[i]);
                r5_n[i]    <= r4_n[i];
                r6_q[i]    <= n_q[i];
                r6_n[i]    <= r5_n[i];
                r7_sq[i]   <= n_abs[i] * n_abs[i];
                r7_q[i]    <= r6_q[i];
                r7_n[i]    <= r6_n[i];
                r8_q[i]    <= r7_q[i];
                r8_n[i]    <= r7_n[i];
            end
            r1_eta  <= i_eta;
            r2_cos  <= n_cos;
            r2_eta  <= r1_eta;
            r3_eta  <= r2_eta;
            r4_eta  <= r3_eta;
            r8_diff <= n_diff;
        end
    end

    assign o_valid   = r_vld[7];
    assign o_diff    = r8_diff;
    assign o_side.n0 = r8_n[0];
    assign o_side.n1 = r8_n[1];
    assign o_side.n2 = r8_n[2];
    assign o_side.q0 = r8_q[0];
    assign o_side.q1 = r8_q[1];
    assign o_side.q2 = r8_q[2];

endmodule

### hdl/vru_sqrt.sv
module vru_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vru_pkg::t_ctl                 i_ctl,
    input  logic [vru_pkg::LEN_W-1:0]     i_diff,
    input  vru_pkg::t_side                i_side,
    output logic                          o_valid,
    output logic [vru_pkg::ROOT_W-1:0]    o_root,
    output vru_pkg::t_side                o_side
);

    localparam int ROOT_W = vru_pkg::ROOT_W;
    localparam int SQ_W   = vru_pkg::SQ_W;

    // one result bit per stage, restoring digit recurrence
    logic [SQ_W-1:0]    r_v   [ROOT_W];
    logic [SQ_W-1:0]    r_res [ROOT_W];
    logic               r_vld [ROOT_W];
    vru_pkg::t_side     r_side [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (ROOT_W - 1 - s));
        logic [SQ_W-1:0] w_v;
        logic [SQ_W-1:0] w_res;
        logic            w_vld;
        vru_pkg::t_side  w_side;
        logic [SQ_W-1:0] n_trial;
        logic [SQ_W-1:0] n_v;
        logic [SQ_W-1:0] n_res;

        if (s == 0) begin : g_first
            assign w_v    = SQ_W'(i_diff);
            assign w_res  = '0;
            assign w_vld  = i_ctl.valid;
            assign w_side = i_side;
        end else begin : g_next
            assign w_v    = r_v[s-1];
            assign w_res  = r_res[s-1];
            assign w_vld  = r_vld[s-1];
            assign w_side = r_side[s-1];
        end

        always_comb begin
            n_trial = w_res + BIT;
            if (w_v >= n_trial) begin
                n_v   = w_v - n_trial;
                n_res = (w_res >> 1) + BIT;
            end else begin
                n_v   = w_v;
                n_res = w_res >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[s] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_v[s]    <= n_v;
                r_res[s]  <= n_res;
                r_side[s] <= w_side;
            end
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_root  = r_res[ROOT_W-1][ROOT_W-1:0];
    assign o_side  = r_side[ROOT_W-1];

endmodule

### hdl/vru_back.sv
module vru_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  vru_pkg::t_ctl                 i_ctl,
    input  logic [vru_pkg::ROOT_W-1:0]    i_root,
    input  vru_pkg::t_side                i_side,
    output logic                          o_valid,
    output logic signed [vru_pkg::OUT_W-1:0] o_out [3]
);

    localparam int F      = vru_pkg::F;
    localparam int OUT_W  = vru_pkg::OUT_W;
    localparam int PAR_W  = vru_pkg::PAR_W;
    localparam int SUM_W  = vru_pkg::SUM_W;

    localparam logic signed [SUM_W-1:0] OMAX = SUM_W'((1 << (OUT_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] OMIN = -SUM_W'(1 << (OUT_W - 1));

    logic                     r1_vld;
    logic                     r2_vld;
    logic signed [PAR_W-1:0]  r1_prod [3];
    vru_pkg::t_q              r1_q [3];
    logic signed [OUT_W-1:0]  r2_out [3];

    vru_pkg::t_in             w_n [3];
    vru_pkg::t_q              w_q [3];
    logic signed [PAR_W-1:0]  n_neg [3];
    logic signed [SUM_W-1:0]  n_sum [3];

    assign w_n[0] = i_side.n0;
    assign w_n[1] = i_side.n1;
    assign w_n[2] = i_side.n2;
    assign w_q[0] = i_side.q0;
    assign w_q[1] = i_side.q1;
    assign w_q[2] = i_side.q2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_neg[i] = -r1_prod[i];
            n_sum[i] = SUM_W'(r1_q[i]) + SUM_W'(n_neg[i] >>> F);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else if (i_ctl.en) begin
            r1_vld <= i_ctl.valid;
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int i = 0; i < 3; i++) begin
                r1_prod[i] <= PAR_W'(w_n[i]) * PAR_W'($signed({1'b0, i_root}));
                r1_q[i]    <= w_q[i];
                if (n_sum[i] > OMAX) begin
                    r2_out[i] <= OMAX[OUT_W-1:0];
                end else if (n_sum[i] < OMIN) begin
                    r2_out[i] <= OMIN[OUT_W-1:0];
                end else begin
                    r2_out[i] <= n_sum[i][OUT_W-1:0];
                end
            end
        end
    end

    assign o_valid = r2_vld;
    assign o_out   = r2_out;

endmodule

### hdl/vector_refraction_unit_top.sv
// Refracts a unit direction through a surface with normal n and index ratio eta
// (Snell's law in vector form, Q2.16 in, Q4.16 out, each component saturated
// at +-8). Total internal reflection is not flagged: the square root is taken
// of |1 - |perp|^2|. One item is accepted per clock unless the output stalls;
// it passes 8 arithmetic stages, a 30-stage square root taking one root bit per
// stage and 2 output stages. A stall on the output holds the whole pipeline.
module vector_refraction_unit_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [17:0]         i_dir_x,
    input  logic signed [17:0]         i_dir_y,
    input  logic signed [17:0]         i_dir_z,
    input  logic signed [17:0]         i_norm_x,
    input  logic signed [17:0]         i_norm_y,
    input  logic signed [17:0]         i_norm_z,
    input  logic [17:0]                i_eta_ratio,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [19:0]         o_out_x,
    output logic signed [19:0]         o_out_y,
    output logic signed [19:0]         o_out_z
);

    vru_pkg::t_ctl                     w_ctl_in;
    vru_pkg::t_ctl                     w_ctl_sq;
    vru_pkg::t_ctl                     w_ctl_bk;
    logic                              w_en;
    vru_pkg::t_in                      w_dir [3];
    vru_pkg::t_in                      w_norm [3];
    logic                              w_f_vld;
    logic [vru_pkg::LEN_W-1:0]         w_diff;
    vru_pkg::t_side                    w_f_side;
    logic                              w_s_vld;
    logic [vru_pkg::ROOT_W-1:0]        w_root;
    vru_pkg::t_side                    w_s_side;
    logic signed [vru_pkg::OUT_W-1:0]  w_out [3];

    assign w_en     = !(o_valid && i_stall);
    assign o_stall  = !w_en;
    assign w_ctl_in = '{en: w_en, valid: i_valid};
    assign w_ctl_sq = '{en: w_en, valid: w_f_vld};
    assign w_ctl_bk = '{en: w_en, valid: w_s_vld};

    assign w_dir[0]  = i_dir_x;
    assign w_dir[1]  = i_dir_y;
    assign w_dir[2]  = i_dir_z;
    assign w_norm[0] = i_norm_x;
    assign w_norm[1] = i_norm_y;
    assign w_norm[2] = i_norm_z;

    vru_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_in),
        .i_dir   (w_dir),
        .i_norm  (w_norm),
        .i_eta   (i_eta_ratio),
        .o_valid (w_f_vld),
        .o_diff  (w_diff),
        .o_side  (w_f_side)
    );

    vru_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_sq),
        .i_diff  (w_diff),
        .i_side  (w_f_side),
        .o_valid (w_s_vld),
        .o_root  (w_root),
        .o_side  (w_s_side)
    );

    vru_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl_bk),
        .i_root  (w_root),
        .i_side  (w_s_side),
        .o_valid (o_valid),
        .o_out   (w_out)
    );

    assign o_out_x = w_out[0];
    assign o_out_y = w_out[1];
    assign o_out_z = w_out[2];

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_stall_cause: assert property (@(posedge i_clk) o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held output");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_out_x) && $stable(o_out_y)
            && $stable(o_out_z)))
        else $error("held result changed");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int LATENCY   = 40;
    localparam int CYC_LIMIT = 400000;

    typedef struct {
        logic signed [17:0] dx, dy, dz, nx, ny, nz;
        logic [17:0]        eta;
    } t_ray;

    typedef struct {
        logic signed [19:0] x, y, z;
    } t_dirv;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic signed [17:0] i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    logic signed [17:0] i_norm_x = '0, i_norm_y = '0, i_norm_z = '0;
    logic [17:0] i_eta_ratio = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [19:0] o_out_x, o_out_y, o_out_z;

    t_dirv refracted_q[$];
    int    n_errors = 0;
    int    cycles = 0;
    int    rx_gap = 0;        // extra stall cycles left in the current burst
    bit    quiet = 1'b0;      // no idling on either side
    bit    hold_rx = 1'b0;    // long receiver hold-off

    always #10 i_clk = ~i_clk;

    vector_refraction_unit_top i_dut (.*);

    function automatic longint floor_shift(longint v);
        return v >>> 16;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic t_dirv refract(t_ray r);
        longint d[3], n[3], q[3];
        longint eta, dot, cs, p, par;
        longint unsigned len2, a, one2, diff, root;
        t_dirv o;
        d = '{longint'(r.dx), longint'(r.dy), longint'(r.dz)};
        n = '{longint'(r.nx), longint'(r.ny), longint'(r.nz)};
        eta = longint'({1'b0, r.eta});
        dot = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
        cs = floor_shift(-dot);
        if (cs > 65536) cs = 65536;
        len2 = 0;
        for (int i = 0; i < 3; i++) begin
            p = d[i] + floor_shift(n[i] * cs);
            q[i] = clamp(floor_shift(eta * p), -64'sd2147483648, 64'sd2147483648);
            a = q[i] < 0 ? -q[i] : q[i];
            len2 += a * a;
        end
        one2 = 64'd1 << 32;
        diff = len2 >= one2 ? len2 - one2 : one2 - len2;
        root = int_sqrt(diff);
        par = floor_shift(-(n[0] * longint'(root)));
        o.x = 20'(clamp(q[0] + par, -524288, 524287));
        par = floor_shift(-(n[1] * longint'(root)));
        o.y = 20'(clamp(q[1] + par, -524288, 524287));
        par = floor_shift(-(n[2] * longint'(root)));
        o.z = 20'(clamp(q[2] + par, -524288, 524287));
        return o;
    endfunction

    task automatic report(string what, logic signed [19:0] got, logic signed [19:0] want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
        n_errors++;
    endtask

    // receiver: random stall bursts, long hold-off on request
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else if (hold_rx) begin
            i_stall <= 1'b1;
        end else if (quiet) begin
            i_stall <= 1'b0;
        end else if (rx_gap != 0) begin
            rx_gap  <= rx_gap - 1;
            i_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            rx_gap  <= $urandom_range(0, 3);
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_dirv want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (refracted_q.size() == 0) begin
                $display("unexpected item at cycle %0d", cycles);
                n_errors++;
            end else begin
                want = refracted_q.pop_front();
                if (o_out_x !== want.x) report("out_x", o_out_x, want.x);
                if (o_out_y !== want.y) report("out_y", o_out_y, want.y);
                if (o_out_z !== want.z) report("out_z", o_out_z, want.z);
            end
        end
    end

    task automatic send_ray(t_ray r);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_dir_x <= r.dx; i_dir_y <= r.dy; i_dir_z <= r.dz;
        i_norm_x <= r.nx; i_norm_y <= r.ny; i_norm_z <= r.nz;
        i_eta_ratio <= r.eta;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        refracted_q.push_back(refract(r));
    endtask

    task automatic idle_input();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [17:0] any18();
        return 18'($urandom);
    endfunction

    // roughly unit component, sign random
    function automatic logic signed [17:0] near_unit();
        return 18'(($signed($urandom_range(0, 70000)) - 35000)
                   * ($urandom_range(0, 1) ? 1 : 2));
    endfunction

    function automatic t_ray random_ray();
        t_ray r;
        if ($urandom_range(0, 3) == 0) begin
            r = '{any18(), any18(), any18(), any18(), any18(), any18(), 18'($urandom)};
        end else begin
            r = '{near_unit(), near_unit(), near_unit(), near_unit(), near_unit(),
                  near_unit(), 18'($urandom_range(30000, 110000))};
        end
        return r;
    endfunction

    task automatic test_directed();
        logic signed [17:0] mx = 18'sh1FFFF, mn = -18'sh20000, one = 18'sd65536;
        send_ray('{18'sd0, 18'sd0, -one, 18'sd0, 18'sd0, one, 18'd65536});
        send_ray('{18'sd0, 18'sd0, -one, 18'sd0, 18'sd0, one, 18'd43690});
        send_ray('{18'sd46341, 18'sd0, -18'sd46341, 18'sd0, 18'sd0, one, 18'd98304});
        send_ray('{one, 18'sd0, 18'sd0, 18'sd0, 18'sd0, one, 18'd131072});
        send_ray('{18'sd0, 18'sd0, one, 18'sd0, 18'sd0, one, 18'd65536});
        send_ray('{mx, mx, mx, mx, mx, mx, 18'h3FFFF});
        send_ray('{mn, mn, mn, mn, mn, mn, 18'h3FFFF});
        send_ray('{mx, mn, mx, mn, mx, mn, 18'h3FFFF});
        send_ray('{mn, mx, mn, mx, mn, mx, 18'h3FFFF});
        send_ray('{mx, mx, mx, mn, mn, mn, 18'h3FFFF});
        send_ray('{mn, mn, mn, mx, mx, mx, 18'd0});
        send_ray('{18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'sd0, 18'd0});
        send_ray('{18'sd0, 18'sd0, 18'sd0, mx, mn, mx, 18'd0});
        send_ray('{-18'sd1, -18'sd1, -18'sd1, -18'sd1, -18'sd1, -18'sd1, 18'd1});
        send_ray('{18'sd1, 18'sd1, 18'sd1, mn, mn, mn, 18'h3FFFF});
        send_ray('{18'sh15555, 18'sh2AAAA, 18'sd0, 18'sh2AAAA, 18'sh15555, 18'sd0, 18'h2AAAA});
        send_ray('{18'sh2AAAA, 18'sh15555, 18'sd0, 18'sh15555, 18'sh2AAAA, 18'sd0, 18'h15555});
    endtask

    task automatic test_random(int count);
        repeat (count) send_ray(random_ray());
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        fork
            begin
                hold_rx = 1'b1;
                repeat (120) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            test_random(150);
        join
    endtask

    task automatic test_drain_pause();
        idle_input();
        wait (refracted_q.size() == 0);
        test_random(100);
    endtask

    task automatic test_no_idling();
        quiet = 1'b1;
        test_random(300);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(1000);
        test_backpressure();
        test_drain_pause();
        test_random(200);
        test_no_idling();
        idle_input();
        wait (refracted_q.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_errors == 0 && refracted_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
